>>> design/gfa_pkg.sv
// shared types and constants for the gravity force accumulator
package gfa_pkg;

  // width of the shared bit-serial unit: a 65 bit d^2 times a 16 bit theta^2
  localparam int unsigned UNIT_W = 81;
  localparam int unsigned ITER_W = 7;
  // left alignment of a 64 bit dividend and a 66 bit radicand in the unit
  localparam int unsigned DIV_ALIGN = UNIT_W - 64;
  localparam int unsigned SQ_ALIGN = UNIT_W - 66;

  // configuration register index and reset value
  localparam logic REG_THETA_SQ = 1'b0;
  localparam logic [15:0] THETA_RESET = 16'd5898;

  // operations of the shared unit
  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } gfa_op_t;

  // request from the sequencer to the unit
  typedef struct packed {
    logic              start;
    gfa_op_t           op;
    logic [ITER_W-1:0] iters;
  } gfa_req_t;

  // unit status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } gfa_stat_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_QX,
    S_QY,
    S_DECIDE,
    S_HH,
    S_TD2,
    S_SQRT,
    S_DACC,
    S_CXM,
    S_CXD,
    S_CYM,
    S_CYD,
    S_ADD,
    S_RESULT
  } gfa_state_t;

endpackage

>>> design/gfa_unit.sv
// shared bit-serial unit: shift-add multiply, restoring divide, restoring square root
module gfa_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gfa_pkg::gfa_req_t            req,
  input  logic [gfa_pkg::UNIT_W-1:0]   opa,
  input  logic [gfa_pkg::UNIT_W-1:0]   opb,
  output gfa_pkg::gfa_stat_t           stat,
  output logic [gfa_pkg::UNIT_W-1:0]   result
);
  import gfa_pkg::*;

  // a: product or partial remainder, b: multiplicand or divisor
  // c: multiplier, dividend or radicand, q: quotient or root
  logic [UNIT_W-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, q_r, q_nxt;
  gfa_op_t           op_r, op_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [UNIT_W-1:0] add_a, add_b;
  logic              add_sub;
  logic [UNIT_W:0]   add_res;

  // the one adder/subtractor, top bit is the borrow on subtract
  assign add_res = {1'b0, add_a} + (add_sub ? ~{1'b0, add_b} : {1'b0, add_b})
                   + {{UNIT_W{1'b0}}, add_sub};

  // operand selection per operation
  always_comb begin
    add_a   = a_r;
    add_b   = b_r;
    add_sub = 1'b0;
    unique case (op_r)
      OP_MUL: begin
        add_b = c_r[0] ? b_r : '0;
      end
      OP_DIV: begin
        add_a   = {a_r[UNIT_W-2:0], c_r[UNIT_W-1]};
        add_sub = 1'b1;
      end
      OP_SQRT: begin
        add_a   = {a_r[UNIT_W-3:0], c_r[UNIT_W-1:UNIT_W-2]};
        add_b   = {q_r[UNIT_W-3:0], 2'b01};
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  // load on start, one step per cycle while busy
  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    c_nxt    = c_r;
    q_nxt    = q_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      op_nxt   = req.op;
      cnt_nxt  = req.iters;
      busy_nxt = 1'b1;
      a_nxt    = '0;
      q_nxt    = '0;
      b_nxt    = opb;
      c_nxt    = opb;
      unique case (req.op)
        OP_MUL:  begin b_nxt = opa; c_nxt = opb; end
        OP_DIV:  begin b_nxt = opb; c_nxt = opa << DIV_ALIGN; end
        OP_SQRT: begin c_nxt = opa << SQ_ALIGN; end
        default: begin c_nxt = opb; end
      endcase
    end else if (busy_r) begin
      unique case (op_r)
        OP_MUL: begin
          a_nxt = add_res[UNIT_W-1:0];
          b_nxt = b_r << 1;
          c_nxt = c_r >> 1;
        end
        OP_DIV: begin
          a_nxt = add_res[UNIT_W] ? add_a : add_res[UNIT_W-1:0];
          q_nxt = {q_r[UNIT_W-2:0], ~add_res[UNIT_W]};
          c_nxt = c_r << 1;
        end
        OP_SQRT: begin
          a_nxt = add_res[UNIT_W] ? add_a : add_res[UNIT_W-1:0];
          q_nxt = {q_r[UNIT_W-2:0], ~add_res[UNIT_W]};
          c_nxt = c_r << 2;
        end
        default: begin
          a_nxt = a_r;
        end
      endcase
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    q_r <= q_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = (op_r == OP_MUL) ? a_r : q_r;

endmodule

>>> design/gravity_force_accumulator.sv
// Top level: 2D softened gravity accumulation with a Barnes-Hut cell opening test.
// Zero mass goes straight to the result; coincident points or a target inside the box end
// after the squaring passes, a cell opened by the size test after its two multiplies, and
// an applied item after the root, divide and multiply-divide passes. Items go one at a time
// through the single bit-serial unit, a new one taken only after the result is accepted.
// rst_n is synchronous: sums clear, theta_sq returns to 5898, sequencer idle.
module gravity_force_accumulator #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // target_x, target_y, src_x, src_y, src_mass, box_x, box_y, half_size, pad
  input  logic [255:0] in_tdata,
  // func
  input  logic [0:0]   in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // acc_x, acc_y
  output logic [63:0]  out_tdata,
  // applied, open_cell
  output logic [1:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import gfa_pkg::*;

  localparam logic [64:0] EpsD2 =
    65'(((66'd1 << (2 * FRAC_BITS)) + 66'd50000) / 66'd100000);

  gfa_state_t  state_r, state_nxt;
  logic        launched_r, launched_nxt;
  logic [15:0] theta_r;
  logic        func_r, func_nxt, last_r, last_nxt, inside_r, inside_nxt;
  logic        negx_r, negx_nxt, negy_r, negy_nxt;
  logic        applied_r, applied_nxt, open_r, open_nxt;
  logic [31:0] mass_r, mass_nxt;
  logic [30:0] h_r, h_nxt;
  logic [32:0] ax_r, ax_nxt, ay_r, ay_nxt, dist_r, dist_nxt;
  logic [63:0] t64_r, t64_nxt, prod_r, prod_nxt, acc_r, acc_nxt;
  logic [64:0] d2_r, d2_nxt;
  logic [61:0] hh_r, hh_nxt;
  logic [31:0] sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;

  gfa_req_t          req;
  gfa_stat_t         stat;
  logic [UNIT_W-1:0] opa, opb, res;

  logic [31:0] tx, ty, sx, sy, bx, by;
  logic [32:0] dx, dy, ex, ey, uex, uey;
  logic [63:0] num, den;

  // field unpacking and front-end differences
  always_comb begin
    tx  = in_tdata[31:0];
    ty  = in_tdata[63:32];
    sx  = in_tdata[95:64];
    sy  = in_tdata[127:96];
    bx  = in_tdata[191:160];
    by  = in_tdata[223:192];
    dx  = {sx[31], sx} - {tx[31], tx};
    dy  = {sy[31], sy} - {ty[31], ty};
    ex  = {tx[31], tx} - {bx[31], bx};
    ey  = {ty[31], ty} - {by[31], by};
    uex = ex[32] ? (~ex + 33'd1) : ex;
    uey = ey[32] ? (~ey + 33'd1) : ey;
    num = {32'd0, mass_r} << FRAC_BITS;
    den = 64'(d2_r >> FRAC_BITS) + (64'd1 << FRAC_BITS);
  end

  // add a signed quotient to a sum with saturation to 32 bits
  function automatic logic [31:0] sat_add(input logic [31:0] s, input logic [63:0] q,
                                          input logic neg);
    logic [63:0] c;
    logic [63:0] t;
    c = neg ? (~q + 64'd1) : q;
    t = {{32{s[31]}}, s} + c;
    if (!t[63] && (t[62:31] != '0)) sat_add = 32'h7fff_ffff;
    else if (t[63] && (t[62:31] != '1)) sat_add = 32'h8000_0000;
    else sat_add = t[31:0];
  endfunction

  // sequencer: next state, unit requests and captures
  always_comb begin
    state_nxt    = state_r;
    launched_nxt = launched_r;
    func_nxt     = func_r;
    last_nxt     = last_r;
    inside_nxt   = inside_r;
    negx_nxt     = negx_r;
    negy_nxt     = negy_r;
    applied_nxt  = applied_r;
    open_nxt     = open_r;
    mass_nxt     = mass_r;
    h_nxt        = h_r;
    ax_nxt       = ax_r;
    ay_nxt       = ay_r;
    dist_nxt     = dist_r;
    t64_nxt      = t64_r;
    prod_nxt     = prod_r;
    acc_nxt      = acc_r;
    d2_nxt       = d2_r;
    hh_nxt       = hh_r;
    sum_x_nxt    = sum_x_r;
    sum_y_nxt    = sum_y_r;
    req          = '0;
    opa          = '0;
    opb          = '0;
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          func_nxt    = in_tuser[0];
          last_nxt    = in_tlast;
          mass_nxt    = in_tdata[159:128];
          h_nxt       = in_tdata[254:224];
          negx_nxt    = dx[32];
          negy_nxt    = dy[32];
          ax_nxt      = dx[32] ? (~dx + 33'd1) : dx;
          ay_nxt      = dy[32] ? (~dy + 33'd1) : dy;
          inside_nxt  = (uex <= {2'b00, in_tdata[254:224]}) &&
                        (uey <= {2'b00, in_tdata[254:224]});
          applied_nxt = 1'b0;
          open_nxt    = 1'b0;
          launched_nxt = 1'b0;
          state_nxt   = (in_tdata[159:128] == 32'd0) ? S_RESULT : S_QX;
        end
      end
      S_QX: begin
        req.op = OP_MUL; req.iters = 7'd33;
        opa = UNIT_W'(ax_r); opb = UNIT_W'(ax_r);
        if (!launched_r) begin
          req.start = 1'b1; launched_nxt = 1'b1;
        end else if (stat.done) begin
          t64_nxt = res[63:0]; launched_nxt = 1'b0; state_nxt = S_QY;
        end
      end
      S_QY: begin
        req.op = OP_MUL; req.iters = 7'd33;
        opa = UNIT_W'(ay_r); opb = UNIT_W'(ay_r);
        if (!launched_r) begin
          req.start = 1'b1; launched_nxt = 1'b1;
        end else if (stat.done) begin
          d2_nxt = {1'b0, t64_r} + {1'b0, res[63:0]};
          launched_nxt = 1'b0; state_nxt = S_DECIDE;
        end
      end
      // coincident points and the box test
      S_DECIDE: begin
        if ((d2_r < EpsD2) || (func_r && inside_r)) begin
          open_nxt  = func_r;
          state_nxt = S_RESULT;
        end else begin
          state_nxt = func_r ? S_HH : S_SQRT;
        end
      end
      S_HH: begin
        req.op = OP_MUL; req.iters = 7'd31;
        opa = UNIT_W'(h_r); opb = UNIT_W'(h_r);
        if (!launched_r) begin
          req.start = 1'b1; launched_nxt = 1'b1;
        end else if (stat.done) begin
          hh_nxt = res[61:0]; launched_nxt = 1'b0; state_nxt = S_TD2;
        end
      end
      // opening test: 2*h^2*2^16 < theta_sq*d2
      S_TD2: begin
        req.op = OP_MUL; req.iters = 7'd16;
        opa = UNIT_W'(d2_r); opb = UNIT_W'(theta_r);
        if (!launched_r) begin
          req.start = 1'b1; launched_nxt = 1'b1;
        end else if (stat.done) begin
          launched_nxt = 1'b0;
          if ({2'b00, hh_r, 17'd0} < res) begin
            state_nxt = S_SQRT;
          end else begin
            open_nxt  = 1'b1;
            state_nxt = S_RESULT;
          end
        end
      end
      S_SQRT: begin
        req.op = OP_SQRT; req.iters = 7'd33;
        opa = UNIT_W'(d2_r);
        if (!launched_r) begin
          req.start = 1'b1; launched_nxt = 1'b1;
        end else if (stat.done) begin
          dist_nxt = (res[32:0] == 33'd0) ? 33'd1 : res[32:0];
          launched_nxt = 1'b0; state_nxt = S_DACC;
        end
      end
      S_DACC: begin
        req.op = OP_DIV; req.iters = 7'd64;
        opa = UNIT_W'(num); opb = UNIT_W'(den);
        if (!launched_r) begin
          req.start = 1'b1; launched_nxt = 1'b1;
        end else if (stat.done) begin
          acc_nxt = res[63:0]; launched_nxt = 1'b0; state_nxt = S_CXM;
        end
      end
      S_CXM: begin
        req.op = OP_MUL; req.iters = 7'd33;
        opa = UNIT_W'(acc_r); opb = UNIT_W'(ax_r);
        if (!launched_r) begin
          req.start = 1'b1; launched_nxt = 1'b1;
        end else if (stat.done) begin
          prod_nxt = res[63:0]; launched_nxt = 1'b0; state_nxt = S_CXD;
        end
      end
      S_CXD: begin
        req.op = OP_DIV; req.iters = 7'd64;
        opa = UNIT_W'(prod_r); opb = UNIT_W'(dist_r);
        if (!launched_r) begin
          req.start = 1'b1; launched_nxt = 1'b1;
        end else if (stat.done) begin
          t64_nxt = res[63:0]; launched_nxt = 1'b0; state_nxt = S_CYM;
        end
      end
      S_CYM: begin
        req.op = OP_MUL; req.iters = 7'd33;
        opa = UNIT_W'(acc_r); opb = UNIT_W'(ay_r);
        if (!launched_r) begin
          req.start = 1'b1; launched_nxt = 1'b1;
        end else if (stat.done) begin
          prod_nxt = res[63:0]; launched_nxt = 1'b0; state_nxt = S_CYD;
        end
      end
      S_CYD: begin
        req.op = OP_DIV; req.iters = 7'd64;
        opa = UNIT_W'(prod_r); opb = UNIT_W'(dist_r);
        if (!launched_r) begin
          req.start = 1'b1; launched_nxt = 1'b1;
        end else if (stat.done) begin
          launched_nxt = 1'b0; state_nxt = S_ADD;
        end
      end
      // y quotient is still held in the unit
      S_ADD: begin
        sum_x_nxt   = sat_add(sum_x_r, t64_r, negx_r);
        sum_y_nxt   = sat_add(sum_y_r, res[63:0], negy_r);
        applied_nxt = 1'b1;
        state_nxt   = S_RESULT;
      end
      S_RESULT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (last_r) begin
            sum_x_nxt = '0;
            sum_y_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      launched_r <= 1'b0;
      sum_x_r    <= '0;
      sum_y_r    <= '0;
      applied_r  <= 1'b0;
      open_r     <= 1'b0;
      last_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      launched_r <= launched_nxt;
      sum_x_r    <= sum_x_nxt;
      sum_y_r    <= sum_y_nxt;
      applied_r  <= applied_nxt;
      open_r     <= open_nxt;
      last_r     <= last_nxt;
    end
  end

  // item payload and intermediates
  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    inside_r <= inside_nxt;
    negx_r   <= negx_nxt;
    negy_r   <= negy_nxt;
    mass_r   <= mass_nxt;
    h_r      <= h_nxt;
    ax_r     <= ax_nxt;
    ay_r     <= ay_nxt;
    dist_r   <= dist_nxt;
    t64_r    <= t64_nxt;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    d2_r     <= d2_nxt;
    hh_r     <= hh_nxt;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      theta_r <= THETA_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_THETA_SQ)) begin
      theta_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_THETA_SQ) ? {16'd0, theta_r} : 32'd0;

  gfa_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .opa    (opa),
    .opb    (opb),
    .stat   (stat),
    .result (res)
  );

  assign out_tdata = {sum_y_r, sum_x_r};
  assign out_tuser = {open_r, applied_r};
  assign out_tlast = last_r;

  // input and output sides are never open together
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input ready while result pending");

  // a result never both applies a force and asks for opening
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(applied_r && open_r)) else $error("applied and open both set");

  // sums clear after the final transaction of a target
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (sum_x_r == '0 && sum_y_r == '0))
    else $error("sums not cleared after last");

  // the unit is idle whenever a new item is taken
  a_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !stat.busy) else $error("unit busy at accept");

endmodule

>>> tb/gravity_force_accumulator_tb.sv
// self-checking testbench for the gravity force accumulator
module gravity_force_accumulator_tb;
  import gfa_pkg::*;

  localparam int CLK_HALF = 5;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam logic [2:0] ADDR_THETA_SQ = 3'(REG_THETA_SQ) << 2;
  localparam logic [127:0] NEAR_D2 = ((128'd1 << 32) + 128'd50000) / 128'd100000;

  // one interaction as it goes into the block
  typedef struct {
    bit              func;
    int              tx, ty, sx, sy;
    int unsigned     mass;
    int              bx, by;
    bit [30:0]       half;
    bit              last;
    bit              pad;
  } interaction_t;

  // one expected result
  typedef struct {
    bit [31:0] acc_x, acc_y;
    bit        applied, open_cell, done_res;
  } force_result_t;

  // force predictor and store of expected sums
  class force_scoreboard;
    force_result_t pending_q[$];
    bit [15:0]     theta_sq = THETA_RESET;
    longint        sum_x = 0, sum_y = 0;
    int            errors = 0;

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // pull toward the source, added into the saturating sums
    function void add_pull(longint dx, longint dy, logic [127:0] d2, logic [31:0] mass);
      logic [127:0] root, cand;
      logic [63:0]  den, acc, root_d, ax, ay;
      longint       cx, cy;
      root = 0;
      for (int b = 32; b >= 0; b--) begin
        cand = root | (128'd1 << b);
        if (cand * cand <= d2) root = cand;
      end
      root_d = root[63:0];
      if (root_d == 0) root_d = 1;
      den = 64'(d2 >> 16) + 64'd65536;
      acc = ({32'd0, mass} << 16) / den;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      cx = longint'((acc * ax) / root_d);
      cy = longint'((acc * ay) / root_d);
      if (dx < 0) cx = -cx;
      if (dy < 0) cy = -cy;
      sum_x = sat32(sum_x + cx);
      sum_y = sat32(sum_y + cy);
    endfunction

    function void note_input(interaction_t it);
      longint        dx, dy, ex, ey;
      logic [127:0]  ax, ay, d2, lhs, rhs;
      logic [63:0]   hh;
      bit            near, in_box;
      force_result_t r;
      r.applied = 0;
      r.open_cell = 0;
      if (it.mass != 0) begin
        dx = longint'(it.sx) - longint'(it.tx);
        dy = longint'(it.sy) - longint'(it.ty);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        d2 = ax * ax + ay * ay;
        near = d2 < NEAR_D2;
        if (!it.func) begin
          if (!near) begin
            add_pull(dx, dy, d2, it.mass);
            r.applied = 1;
          end
        end else begin
          ex = longint'(it.tx) - longint'(it.bx);
          ey = longint'(it.ty) - longint'(it.by);
          if (ex < 0) ex = -ex;
          if (ey < 0) ey = -ey;
          in_box = (ex <= longint'(it.half)) && (ey <= longint'(it.half));
          hh = 64'(it.half);
          lhs = 128'(2 * hh * hh) << 16;
          rhs = 128'(theta_sq) * d2;
          if (!in_box && !near && lhs < rhs) begin
            add_pull(dx, dy, d2, it.mass);
            r.applied = 1;
          end else begin
            r.open_cell = 1;
          end
        end
      end
      r.acc_x = sum_x[31:0];
      r.acc_y = sum_y[31:0];
      r.done_res = it.last;
      if (it.last) begin
        sum_x = 0;
        sum_y = 0;
      end
      pending_q = {pending_q, r};
    endfunction

    function void check_result(bit [63:0] data, bit [1:0] user, bit last);
      force_result_t e;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction data=%h", data);
        return;
      end
      e = pending_q.pop_front();
      if (data[31:0] !== e.acc_x || data[63:32] !== e.acc_y || user[0] !== e.applied ||
          user[1] !== e.open_cell || last !== e.done_res) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: exp acc %h %h app %b open %b done %b, got %h %h %b %b %b",
                   e.acc_x, e.acc_y, e.applied, e.open_cell, e.done_res,
                   data[31:0], data[63:32], user[0], user[1], last);
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [255:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  force_scoreboard sb = new();
  bit              quiet = 0;
  int              out_stall = 0;
  longint          cycles = 0;

  gravity_force_accumulator dut (.*);

  always #CLK_HALF clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver backpressure in random bursts
  always @(posedge clk) begin
    if (!quiet && out_stall == 0 && $urandom_range(0, 19) == 0)
      out_stall = $urandom_range(1, 16);
    if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
  end

  task automatic send_item(interaction_t it);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {it.pad, it.half, it.by, it.bx, it.mass, it.sy, it.sx, it.ty, it.tx};
    in_tuser <= it.func;
    in_tlast <= it.last;
    do @(posedge clk); while (!in_tready);
    sb.note_input(it);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // apb write: setup then access phase
  task automatic write_theta(bit [15:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_THETA_SQ;
    cfg_pwdata <= {16'($urandom_range(0, 65535)), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    sb.theta_sq = val;
    @(posedge clk);
  endtask

  function automatic int rnd_scaled();
    int v;
    v = $urandom;
    return v >>> $urandom_range(1, 31);
  endfunction

  function automatic interaction_t mk(bit func, int tx, int ty, int sx, int sy,
                                      int unsigned mass, int bx, int by, bit [30:0] half,
                                      bit last);
    interaction_t it;
    it = '{func, tx, ty, sx, sy, mass, bx, by, half, last, 1'b0};
    return it;
  endfunction

  // random interaction around a given target
  function automatic interaction_t rnd_item(int tx, int ty, bit last);
    interaction_t it;
    it.func = 1'($urandom_range(0, 1));
    it.tx = tx;
    it.ty = ty;
    it.sx = tx + rnd_scaled();
    it.sy = ty + rnd_scaled();
    if ($urandom_range(0, 15) == 0) begin
      it.sx = $urandom;
      it.sy = $urandom;
    end
    it.mass = $urandom_range(0, 9) == 0 ? 0 : $urandom >> $urandom_range(0, 31);
    it.bx = $urandom_range(0, 1) ? it.sx + (rnd_scaled() >>> 4) : tx + rnd_scaled();
    it.by = $urandom_range(0, 1) ? it.sy + (rnd_scaled() >>> 4) : ty + rnd_scaled();
    it.half = 31'(($urandom >> 1) >> $urandom_range(0, 31));
    it.last = last;
    it.pad = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic random_phase(int count);
    int tx, ty, len;
    while (count > 0) begin
      tx = $urandom_range(0, 3) == 0 ? int'($urandom) : rnd_scaled();
      ty = $urandom_range(0, 3) == 0 ? int'($urandom) : rnd_scaled();
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) send_item(rnd_item(tx, ty, i == len - 1));
      count -= len;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part with the reset theta
    send_item(mk(0, 0, 0, 32'h10000, 0, 0, 0, 0, 0, 0));                 // zero mass particle
    send_item(mk(1, 0, 0, 32'h100000, 0, 0, 0, 0, 0, 0));                // zero mass cell
    send_item(mk(0, 5, 5, 5, 5, 32'h10000, 0, 0, 0, 0));                 // coincident particle
    send_item(mk(1, 5, 5, 6, 5, 32'h10000, 32'h7fff0000, 0, 1, 0));      // coincident cell
    send_item(mk(0, 0, 0, 32'h30000, 32'h40000, 32'h50000, 0, 0, 0, 1)); // plain pull, last
    send_item(mk(1, 0, 0, 32'h1000000, 0, 32'h10000,
                 32'h1000000, 0, 31'h100000, 0));                        // far cell, applied
    send_item(mk(1, 32'h20000, 0, 32'h1000000, 0, 32'h10000,
                 0, 0, 31'h20000, 0));                                   // target on box edge
    send_item(mk(1, 0, 0, 32'h100000, 0, 32'h10000,
                 32'h100000, 0, 31'h7ffff, 0));                          // size test opens
    send_item(mk(0, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                 32'hffffffff, 0, 0, 0, 1));                             // extreme span
    for (int i = 0; i < 4; i++)                                          // saturation
      send_item(mk(0, 0, 0, 32'h100, 32'h100, 32'hffffffff, 0, 0, 0, i == 3));
    for (int i = 0; i < 4; i++)
      send_item(mk(0, 0, 0, -32'sh100, -32'sh100, 32'hffffffff, 0, 0, 0, i == 3));
    send_item(mk(1, 32'h7fffffff, 32'h80000000, 0, 0, 32'hffffffff,
                 32'h80000000, 32'h7fffffff, 31'h7fffffff, 1));          // huge box
    drain();

    // sweep the opening angle through its extremes
    write_theta(16'd0);
    random_phase(300);
    drain();
    write_theta(16'hffff);
    random_phase(400);
    drain();
    write_theta(16'($urandom_range(1, 65534)));
    random_phase(500);
    drain();
    write_theta(16'h5555);
    quiet = 1;
    random_phase(550);
    drain();

    repeat (500) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
